// File: sv/stepper_command_sequencer_macros.svh
// assertion macros used by the checker file
`ifndef STEPPER_COMMAND_SEQUENCER_MACROS_SVH
`define STEPPER_COMMAND_SEQUENCER_MACROS_SVH

// clocked check, off while reset is held
`define SCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication check: antecedent, then consequent on the same edge
`define SCS_ASSERT_IMP(lbl, ante, cons, msg) \
  `SCS_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: sv/scs_pkg.sv
`timescale 1ns / 1ps

package scs_pkg;

  localparam int TICK_BITS_DEFAULT   = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int PHASE_TICKS_W       = 16;
  localparam logic [PHASE_TICKS_W-1:0] PHASE_TICKS_RESET = 16'd2500;

  // item kinds
  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // result status codes
  localparam logic [1:0] ST_TICK      = 2'd0;
  localparam logic [1:0] ST_ACCEPT    = 2'd1;
  localparam logic [1:0] ST_BUSY      = 2'd2;
  localparam logic [1:0] ST_BAD_MOTOR = 2'd3;

  // motor codes
  localparam logic [1:0] MOTOR_X    = 2'd0;
  localparam logic [1:0] MOTOR_Y    = 2'd1;
  localparam logic [1:0] MOTOR_Z    = 2'd2;
  localparam logic [1:0] MOTOR_NONE = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] command_byte;
  } scs_in_t;

  typedef struct packed {
    logic [3:0] coils_x;
    logic [3:0] coils_y;
    logic [3:0] coils_z;
    logic       busy_res;
    logic [1:0] status;
    logic       run_done;
  } scs_out_t;

  // classified item as it travels from front to back
  typedef struct packed {
    logic       is_tick;
    logic       reverse;
    logic [1:0] motor;
    logic [4:0] rot_m1;
  } scs_op_t;

  // two adjacent coils per phase, mirrored for reverse
  function automatic logic [3:0] phase_coils(input logic [1:0] idx, input logic rev);
    logic [1:0] a;
    logic [1:0] b;
    a = idx + 2'd1;
    b = idx + 2'd2;
    if (rev) begin
      a = 2'd3 - a;
      b = 2'd3 - b;
    end
    return (4'b0001 << a) | (4'b0001 << b);
  endfunction

endpackage

// File: sv/scs_front.sv
`timescale 1ns / 1ps

module scs_front import scs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  scs_in_t in_data,
  output logic    op_valid,
  input  logic    op_ready,
  output scs_op_t op
);

  logic    front_valid_r;
  logic    front_valid_nxt;
  scs_op_t front_op_r;
  scs_op_t decoded;

  // split the command byte into its fields
  always_comb begin
    decoded.is_tick = (in_data.kind == KIND_TICK);
    decoded.reverse = in_data.command_byte[0];
    decoded.motor   = in_data.command_byte[2:1];
    decoded.rot_m1  = in_data.command_byte[7:3];
  end

  assign in_ready = !front_valid_r || op_ready;

  always_comb begin
    front_valid_nxt = front_valid_r;
    if (in_valid && in_ready) begin
      front_valid_nxt = 1'b1;
    end else if (op_ready) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      front_op_r <= decoded;
    end
  end

  assign op_valid = front_valid_r;
  assign op       = front_op_r;

endmodule

// File: sv/scs_queue.sv
`timescale 1ns / 1ps

module scs_queue import scs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_valid,
  output logic    wr_ready,
  input  scs_op_t wr_op,
  output logic    rd_valid,
  input  logic    rd_ready,
  output scs_op_t rd_op
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  scs_op_t       mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push;
  logic          pop;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_op    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_op;
    end
  end

endmodule

// File: sv/scs_back.sv
`timescale 1ns / 1ps

module scs_back import scs_pkg::*; #(
  parameter int TICK_COUNTER_BITS = TICK_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [PHASE_TICKS_W-1:0] cfg_wdata,
  input  logic                     op_valid,
  output logic                     op_ready,
  input  scs_op_t                  op,
  output logic                     out_valid,
  input  logic                     out_ready,
  output scs_out_t                 out_data
);

  localparam int TB = TICK_COUNTER_BITS;
  localparam int HW = (TB > PHASE_TICKS_W) ? TB : PHASE_TICKS_W;

  logic [PHASE_TICKS_W-1:0] phase_ticks_r;

  logic [3:0]    coils_x_r, coils_x_nxt;
  logic [3:0]    coils_y_r, coils_y_nxt;
  logic [3:0]    coils_z_r, coils_z_nxt;
  logic [1:0]    motor_r, motor_nxt;
  logic          rev_r, rev_nxt;
  logic [7:0]    left_r, left_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic [TB-1:0] tick_r, tick_nxt;
  logic          run_r, run_nxt;
  logic          out_valid_r, out_valid_nxt;
  scs_out_t      out_data_r;
  scs_out_t      result;

  logic          pop;
  logic [HW-1:0] pt_w;
  logic [HW-1:0] cmax_w;
  logic [HW-1:0] hold_w;
  logic [TB-1:0] hold;
  logic [TB-1:0] tick_inc;
  logic          drive;
  logic [1:0]    drive_motor;
  logic [3:0]    pattern;
  logic [1:0]    status;
  logic          done;

  assign pop      = op_valid && (!out_valid_r || out_ready);
  assign op_ready = !out_valid_r || out_ready;

  // hold length: zero means one, clamp to what the counter can reach
  assign pt_w   = HW'(phase_ticks_r);
  assign cmax_w = HW'({TB{1'b1}});
  always_comb begin
    if (pt_w == '0) begin
      hold_w = HW'(1);
    end else if (pt_w > cmax_w) begin
      hold_w = cmax_w;
    end else begin
      hold_w = pt_w;
    end
  end
  assign hold     = hold_w[TB-1:0];
  assign tick_inc = tick_r + TB'(1);

  always_comb begin
    coils_x_nxt = coils_x_r;
    coils_y_nxt = coils_y_r;
    coils_z_nxt = coils_z_r;
    motor_nxt   = motor_r;
    rev_nxt     = rev_r;
    left_nxt    = left_r;
    idx_nxt     = idx_r;
    tick_nxt    = tick_r;
    run_nxt     = run_r;
    status      = ST_TICK;
    done        = 1'b0;
    drive       = 1'b0;
    drive_motor = motor_r;
    pattern     = 4'b0000;

    if (!op.is_tick) begin
      if (run_r) begin
        status = ST_BUSY;
      end else if (op.motor == MOTOR_NONE) begin
        status = ST_BAD_MOTOR;
      end else begin
        status      = ST_ACCEPT;
        motor_nxt   = op.motor;
        rev_nxt     = op.reverse;
        left_nxt    = {1'b0, op.rot_m1, 2'b11};
        idx_nxt     = 2'd0;
        tick_nxt    = '0;
        run_nxt     = 1'b1;
        drive       = 1'b1;
        drive_motor = op.motor;
        pattern     = phase_coils(2'd0, op.reverse);
      end
    end else if (run_r) begin
      if ((tick_inc >= hold) || (tick_inc == '0)) begin
        tick_nxt = '0;
        drive    = 1'b1;
        if (left_r == 8'd0) begin
          run_nxt = 1'b0;
          done    = 1'b1;
          pattern = 4'b0000;
        end else begin
          left_nxt = left_r - 8'd1;
          idx_nxt  = idx_r + 2'd1;
          pattern  = phase_coils(idx_r + 2'd1, rev_r);
        end
      end else begin
        tick_nxt = tick_inc;
      end
    end

    if (drive) begin
      case (drive_motor)
        MOTOR_X: coils_x_nxt = pattern;
        MOTOR_Y: coils_y_nxt = pattern;
        MOTOR_Z: coils_z_nxt = pattern;
        default: ;
      endcase
    end

    result.coils_x  = coils_x_nxt;
    result.coils_y  = coils_y_nxt;
    result.coils_z  = coils_z_nxt;
    result.busy_res = run_nxt;
    result.status   = status;
    result.run_done = done;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RESET;
    end else if (cfg_we) begin
      phase_ticks_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coils_x_r   <= '0;
      coils_y_r   <= '0;
      coils_z_r   <= '0;
      motor_r     <= '0;
      rev_r       <= 1'b0;
      left_r      <= '0;
      idx_r       <= '0;
      tick_r      <= '0;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        coils_x_r <= coils_x_nxt;
        coils_y_r <= coils_y_nxt;
        coils_z_r <= coils_z_nxt;
        motor_r   <= motor_nxt;
        rev_r     <= rev_nxt;
        left_r    <= left_nxt;
        idx_r     <= idx_nxt;
        tick_r    <= tick_nxt;
        run_r     <= run_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/stepper_command_sequencer.sv
`timescale 1ns / 1ps
// path: a taken beat goes through the front register, then the queue, then the output register to out_
// throughput: one beat per cycle in both directions while the receiver keeps out_ready high
// the front register and a two-entry queue let input and output stall independently
// reset: synchronous active-low rst_n; coils off, no run, queue empty, phase_ticks = 2500
// no clearing pass; beats are taken from the first cycle after reset

module stepper_command_sequencer import scs_pkg::*; #(
  parameter int TICK_COUNTER_BITS = TICK_BITS_DEFAULT,
  parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel: command bytes and ticks
  input  logic                     in_valid,
  output logic                     in_ready,
  input  scs_in_t                  in_data,
  // result channel: one beat per input beat
  output logic                     out_valid,
  input  logic                     out_ready,
  output scs_out_t                 out_data,
  // phase hold length in ticks
  input  logic                     cfg_we,
  input  logic [PHASE_TICKS_W-1:0] cfg_wdata
);

  // front register to queue
  logic    f_valid;
  logic    f_ready;
  scs_op_t f_op;

  // queue to back end
  logic    q_valid;
  logic    q_ready;
  scs_op_t q_op;

  // front: registers the beat and splits the command byte into direction,
  // motor and rotation count
  scs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .op_valid (f_valid),
    .op_ready (f_ready),
    .op       (f_op)
  );

  // short queue decouples the front from back-end stalls on out_ready
  scs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_op    (f_op),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_op    (q_op)
  );

  // back end: run state, tick counter, coil registers and the output register;
  // one queued item is retired per cycle whenever the output register is free
  scs_back #(
    .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .op_valid  (q_valid),
    .op_ready  (q_ready),
    .op        (q_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: sv/scs_checker.sv
`timescale 1ns / 1ps
`include "stepper_command_sequencer_macros.svh"

module scs_checker import scs_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input scs_out_t                 out_data
);

  logic [2:0] driven;

  assign driven = {|out_data.coils_x, |out_data.coils_y, |out_data.coils_z};

  // stalled result beat holds
  `SCS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

  // only one motor is ever energized
  `SCS_ASSERT_IMP(a_one_motor, out_valid, $onehot0(driven), "more than one motor driven")

  // coils are off whenever no run is active
  `SCS_ASSERT_IMP(a_idle_off, out_valid && !out_data.busy_res, driven == 3'b000, "coils on while idle")

  // a run ends only on a tick and leaves the block idle
  `SCS_ASSERT_IMP(a_done_tick, out_valid && out_data.run_done, !out_data.busy_res && out_data.status == ST_TICK, "bad end of run")

  // an accepted command starts a run
  `SCS_ASSERT_IMP(a_accept_busy, out_valid && out_data.status == ST_ACCEPT, out_data.busy_res && driven != 3'b000, "accepted command without a run")

endmodule

bind stepper_command_sequencer scs_checker u_scs_checker (.*);

// File: test/tb_stepper_command_sequencer.sv
`timescale 1ns / 1ps

module tb_stepper_command_sequencer;
  import scs_pkg::*;

  // run time guard for the whole test
  localparam int CYCLE_LIMIT = 400000;
  // mask from the tick counter width of the instance, sets the wrap of the hold counter
  localparam int HOLD_COUNT_MASK = (1 << TICK_BITS_DEFAULT) - 1;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  scs_in_t                  in_data;
  logic                     out_valid;
  logic                     out_ready;
  scs_out_t                 out_data;
  logic                     cfg_we;
  logic [PHASE_TICKS_W-1:0] cfg_wdata;

  // idling knobs, percent of cycles
  int send_idle_pct;
  int recv_stall_pct;
  // long receiver hold-off, counted down by the receiver process
  int hold_off_cycles;

  int error_count;
  int cycle_count;

  // predicted result beats, oldest first
  scs_out_t due_results[$];

  // shadow of the sequencer state
  logic [15:0] hold_ticks;
  logic [3:0]  motor_coils [3];
  logic [1:0]  run_motor;
  logic        run_reverse;
  logic [7:0]  phases_remaining;
  logic [1:0]  phase_idx;
  logic [15:0] hold_count;
  logic        run_in_progress;

  stepper_command_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // two neighboring coils: 0011 rotated left by step+1, bit-reversed for reverse
  function automatic logic [3:0] coil_pair(input logic [1:0] step, input logic rev);
    logic [7:0] doubled;
    logic [3:0] pair;
    doubled = {4'b0011, 4'b0011} << ({1'b0, step} + 3'd1);
    pair = doubled[7:4];
    if (rev) begin
      pair = {pair[0], pair[1], pair[2], pair[3]};
    end
    return pair;
  endfunction

  function automatic logic [7:0] make_cmd(input logic [1:0] motor, input logic [4:0] rot_m1,
                                          input logic rev);
    return {rot_m1, motor, rev};
  endfunction

  // apply one accepted beat to the shadow state and return the coil/status beat it causes
  function automatic scs_out_t predict_drive(input scs_in_t item);
    scs_out_t    res;
    logic [1:0]  motor;
    int unsigned hold;
    int unsigned next_count;
    res = '0;
    res.status = ST_TICK;
    if (item.kind == KIND_CMD) begin
      motor = item.command_byte[2:1];
      if (run_in_progress) begin
        // any command during a run bounces, even motor code three
        res.status = ST_BUSY;
      end else if (motor == MOTOR_NONE) begin
        res.status = ST_BAD_MOTOR;
      end else begin
        res.status = ST_ACCEPT;
        run_motor = motor;
        run_reverse = item.command_byte[0];
        // (rotations * 4) - 1 phases follow the first one
        phases_remaining = {1'b0, item.command_byte[7:3], 2'b11};
        phase_idx = 2'd0;
        hold_count = '0;
        run_in_progress = 1'b1;
        // first phase goes out on the command itself
        motor_coils[motor] = coil_pair(2'd0, run_reverse);
      end
    end else if (run_in_progress) begin
      // zero hold acts as one tick
      hold = (hold_ticks == 16'd0) ? 1 : hold_ticks;
      next_count = (hold_count + 1) & HOLD_COUNT_MASK;
      if (next_count >= hold || next_count == 0) begin
        hold_count = '0;
        if (phases_remaining == 8'd0) begin
          motor_coils[run_motor] = 4'd0;
          run_in_progress = 1'b0;
          res.run_done = 1'b1;
        end else begin
          phases_remaining = phases_remaining - 8'd1;
          phase_idx = phase_idx + 2'd1;
          motor_coils[run_motor] = coil_pair(phase_idx, run_reverse);
        end
      end else begin
        hold_count = next_count[15:0];
      end
    end
    res.coils_x = motor_coils[MOTOR_X];
    res.coils_y = motor_coils[MOTOR_Y];
    res.coils_z = motor_coils[MOTOR_Z];
    res.busy_res = run_in_progress;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // entered and left at a falling edge; valid stays up for a back-to-back beat
  task automatic send_item(input scs_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    // beat taken at this edge
    due_results.push_back(predict_drive(item));
    @(negedge clk);
  endtask

  task automatic send_cmd(input logic [7:0] cmd);
    scs_in_t item;
    item.kind = KIND_CMD;
    item.command_byte = cmd;
    send_item(item);
  endtask

  task automatic send_tick();
    scs_in_t item;
    item.kind = KIND_TICK;
    // byte is ignored for ticks, so let it wander
    item.command_byte = 8'($urandom_range(255));
    send_item(item);
  endtask

  // tick until the shadow state says the run has ended
  task automatic finish_run();
    while (run_in_progress) begin
      send_tick();
    end
  endtask

  // drop valid and wait for every predicted beat to come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // only called with nothing in flight
  task automatic write_hold(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    hold_ticks = value;
  endtask

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------

  // ready changes on the falling edge; a pending hold-off wins over random stalls
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic void check_field(input string name, input logic [3:0] want_v,
                                      input logic [3:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0h actual %0h", name, want_v, got_v);
      error_count++;
    end
  endfunction

  // every taken result beat is matched against the oldest prediction
  always @(posedge clk) begin
    scs_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result beat with nothing predicted: %h", out_data);
        error_count++;
      end else begin
        want = due_results.pop_front();
        check_field("coils_x", want.coils_x, out_data.coils_x);
        check_field("coils_y", want.coils_y, out_data.coils_y);
        check_field("coils_z", want.coils_z, out_data.coils_z);
        check_field("busy_res", 4'(want.busy_res), 4'(out_data.busy_res));
        check_field("status", 4'(want.status), 4'(out_data.status));
        check_field("run_done", 4'(want.run_done), 4'(out_data.run_done));
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_stepper_command_sequencer NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset hold of 2500, idle tick, bad motor, busy rejects, then zero hold acting as one
  task automatic test_reset_hold_and_rejects();
    send_tick();
    send_cmd(make_cmd(MOTOR_NONE, 5'd0, 1'b0));
    send_cmd(make_cmd(MOTOR_X, 5'd0, 1'b0));
    // far short of 2500, so the first phase must hold
    repeat (3) send_tick();
    send_cmd(make_cmd(MOTOR_NONE, 5'd0, 1'b0));
    send_cmd(make_cmd(MOTOR_NONE, 5'd31, 1'b1));
    wait_results_drained();
    write_hold(16'd0);
    finish_run();
    send_tick();
  endtask

  // largest hold mid-run, then shortest holds; reverse order on motors z and y
  task automatic test_hold_extremes();
    send_cmd(make_cmd(MOTOR_NONE, 5'd31, 1'b1));
    wait_results_drained();
    write_hold(16'hFFFF);
    send_cmd(make_cmd(MOTOR_Z, 5'd0, 1'b1));
    repeat (3) send_tick();
    wait_results_drained();
    write_hold(16'd1);
    finish_run();
    send_cmd(make_cmd(MOTOR_Y, 5'd0, 1'b1));
    wait_results_drained();
    write_hold(16'd2);
    finish_run();
  endtask

  // receiver holds off while a 32-rotation run is fed, so the input side must stall
  task automatic test_output_backpressure();
    wait_results_drained();
    write_hold(16'd1);
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 60;
    send_cmd(make_cmd(MOTOR_X, 5'd31, 1'b0));
    finish_run();
  endtask

  // mostly complete runs with random content, stray commands during runs, some raw noise
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int quota);
    int         sent;
    logic [4:0] rot_m1;
    logic [1:0] motor;
    wait_results_drained();
    // short holds keep runs brief; zero shows up too
    write_hold(16'($urandom_range(3)));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(99) < 85) begin
        motor  = 2'($urandom_range(2));
        // mostly short runs, now and then up to 32 rotations
        rot_m1 = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(3));
        send_cmd(make_cmd(motor, rot_m1, 1'($urandom_range(1))));
      end else begin
        send_item(scs_in_t'(9'($urandom_range(511))));
      end
      sent++;
      while (run_in_progress) begin
        if ($urandom_range(99) < 92) begin
          send_tick();
        end else begin
          send_cmd(8'($urandom_range(255)));
        end
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 0;
    error_count     = 0;

    // shadow state matches the block after reset
    hold_ticks       = PHASE_TICKS_RESET;
    motor_coils[0]   = 4'd0;
    motor_coils[1]   = 4'd0;
    motor_coils[2]   = 4'd0;
    run_motor        = MOTOR_X;
    run_reverse      = 1'b0;
    phases_remaining = 8'd0;
    phase_idx        = 2'd0;
    hold_count       = 16'd0;
    run_in_progress  = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_hold_and_rejects();
    test_hold_extremes();
    test_output_backpressure();
    // no idling, sender idle, receiver stalling, both
    test_random_traffic(0, 0, 370);
    test_random_traffic(83, 0, 370);
    test_random_traffic(0, 83, 370);
    test_random_traffic(27, 27, 370);

    wait_results_drained();
    // let any stray beat show up before the verdict
    repeat (10) @(negedge clk);
    if (error_count == 0 && due_results.size() == 0) begin
      $display("tb_stepper_command_sequencer OK");
    end else begin
      $display("tb_stepper_command_sequencer NOT OK");
    end
    $finish;
  end

endmodule
